@@ src/v3n_pkg.sv @@
package v3n_pkg;

   typedef struct packed {
      logic signed [15:0] comp_x;
      logic signed [15:0] comp_y;
      logic signed [15:0] comp_z;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] unit_x;
      logic signed [15:0] unit_y;
      logic signed [15:0] unit_z;
      logic [15:0]        length;
      logic               too_short;
   } rsp_word_type;

   localparam int unsigned SqrtSteps  = 16;
   localparam int unsigned QuotBits   = 15;
   localparam int unsigned DivSteps   = QuotBits;
   localparam int unsigned Stages     = 1 + SqrtSteps + DivSteps + 1;
   localparam logic [1:0]  RegMinMag  = 2'd0;
   localparam logic [15:0] MinMagRst  = 16'd1;

   typedef struct packed {
      logic        sx;
      logic        sy;
      logic        sz;
      logic [15:0] mx;
      logic [15:0] my;
      logic [15:0] mz;
   } comp_info_type;

endpackage

@@ src/vector3_normalize_top.sv @@
// vector3 normalizer: takes one signed q8.8 vector word per cycle and returns one result
// word per input, in order. the pipeline is 33 register stages deep (one sum-of-squares
// stage, 16 square-root stages producing one root bit each, 15 restoring-divide stages
// producing one quotient bit for all three components, one output stage), and a new word is
// accepted every cycle while rsp_stall is low. rsp_stall freezes the whole pipeline.
// min_magnitude is a q8.8 threshold at csr address 0, reset value 1.
module vector3_normalize_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  v3n_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output v3n_pkg::rsp_word_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int unsigned S = v3n_pkg::Stages;
   localparam int unsigned SQ0 = 1;
   localparam int unsigned DV0 = SQ0 + v3n_pkg::SqrtSteps;

   logic [15:0] min_mag_ff;
   logic        advance;

   // per-stage payload
   logic                   vld_ff   [S];
   v3n_pkg::comp_info_type info_ff  [S];
   logic [31:0]            rem_ff   [S];
   logic [15:0]            root_ff  [S];
   logic [16:0]            rx_ff    [S];
   logic [16:0]            ry_ff    [S];
   logic [16:0]            rz_ff    [S];
   logic [14:0]            qx_ff    [S];
   logic [14:0]            qy_ff    [S];
   logic [14:0]            qz_ff    [S];

   assign pready  = 1'b1;
   assign advance = !rsp_stall;
   assign req_stall = rsp_stall;
   assign prdata = (paddr[2] == v3n_pkg::RegMinMag[0]) ? {16'd0, min_mag_ff} : 32'd0;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_mag_ff <= v3n_pkg::MinMagRst;
      end else if (psel && penable && pwrite && paddr[2] == v3n_pkg::RegMinMag[0]) begin
         min_mag_ff <= pwdata[15:0];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < S; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < S; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 0: magnitudes and exact sum of squares
   logic [15:0] ax_in, ay_in, az_in;
   always_comb begin
      ax_in = req_data.comp_x[15] ? 16'(-req_data.comp_x) : req_data.comp_x;
      ay_in = req_data.comp_y[15] ? 16'(-req_data.comp_y) : req_data.comp_y;
      az_in = req_data.comp_z[15] ? 16'(-req_data.comp_z) : req_data.comp_z;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info_ff[0] <= '{sx: req_data.comp_x[15], sy: req_data.comp_y[15],
                         sz: req_data.comp_z[15], mx: ax_in, my: ay_in, mz: az_in};
         rem_ff[0]  <= 32'(32'(ax_in) * 32'(ax_in)) + 32'(32'(ay_in) * 32'(ay_in))
                       + 32'(32'(az_in) * 32'(az_in));
         root_ff[0] <= '0;
      end
   end

   // square root stages: one root bit per stage, rem holds s - root^2
   genvar g;
   generate
      for (g = 0; g < v3n_pkg::SqrtSteps; g++) begin : g_sqrt
         localparam int unsigned B = v3n_pkg::SqrtSteps - 1 - g;
         logic [32:0] trial_in;
         assign trial_in = 33'({16'd0, root_ff[SQ0+g-1]} << (B + 1)) + (33'd1 << (2*B));
         always_ff @(posedge clock) begin
            if (advance) begin
               info_ff[SQ0+g] <= info_ff[SQ0+g-1];
               if ({1'b0, rem_ff[SQ0+g-1]} >= trial_in) begin
                  rem_ff[SQ0+g]  <= 32'({1'b0, rem_ff[SQ0+g-1]} - trial_in);
                  root_ff[SQ0+g] <= root_ff[SQ0+g-1] | 16'(17'd1 << B);
               end else begin
                  rem_ff[SQ0+g]  <= rem_ff[SQ0+g-1];
                  root_ff[SQ0+g] <= root_ff[SQ0+g-1];
               end
            end
         end
      end
   endgenerate

   // entry into divider: partial remainders start at zero
   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff[DV0-1] <= '0;
         ry_ff[DV0-1] <= '0;
         rz_ff[DV0-1] <= '0;
         qx_ff[DV0-1] <= '0;
         qy_ff[DV0-1] <= '0;
         qz_ff[DV0-1] <= '0;
      end
   end

   // restoring divide of mag*2^14 by root: dividend bit k = mag bit (k-14), one per stage
   generate
      for (g = 0; g < v3n_pkg::DivSteps; g++) begin : g_div
         localparam int unsigned K = 30 - g;
         localparam int unsigned P = DV0 + g;
         logic [16:0] dvs;
         logic [17:0] sx_in, sy_in, sz_in;
         logic [30:0] nx, ny, nz;
         assign dvs = {1'b0, root_ff[P-1]};
         // bring down all dividend bits down to the first quotient bit's position at step 0
         always_comb begin
            nx = 31'(info_ff[P-1].mx) << 14;
            ny = 31'(info_ff[P-1].my) << 14;
            nz = 31'(info_ff[P-1].mz) << 14;
            if (g == 0) begin
               sx_in = 18'(nx[30:14]);
               sy_in = 18'(ny[30:14]);
               sz_in = 18'(nz[30:14]);
            end else begin
               sx_in = {rx_ff[P-1], nx[K - 16]};
               sy_in = {ry_ff[P-1], ny[K - 16]};
               sz_in = {rz_ff[P-1], nz[K - 16]};
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               info_ff[P] <= info_ff[P-1];
               root_ff[P] <= root_ff[P-1];
               if (sx_in >= 18'(dvs)) begin
                  rx_ff[P] <= 17'(sx_in - 18'(dvs)); qx_ff[P] <= {qx_ff[P-1][13:0], 1'b1};
               end else begin
                  rx_ff[P] <= 17'(sx_in);             qx_ff[P] <= {qx_ff[P-1][13:0], 1'b0};
               end
               if (sy_in >= 18'(dvs)) begin
                  ry_ff[P] <= 17'(sy_in - 18'(dvs)); qy_ff[P] <= {qy_ff[P-1][13:0], 1'b1};
               end else begin
                  ry_ff[P] <= 17'(sy_in);             qy_ff[P] <= {qy_ff[P-1][13:0], 1'b0};
               end
               if (sz_in >= 18'(dvs)) begin
                  rz_ff[P] <= 17'(sz_in - 18'(dvs)); qz_ff[P] <= {qz_ff[P-1][13:0], 1'b1};
               end else begin
                  rz_ff[P] <= 17'(sz_in);             qz_ff[P] <= {qz_ff[P-1][13:0], 1'b0};
               end
            end
         end
      end
   endgenerate

   // output stage: quotient of the first step saturates only when |c| = len, giving 16384
   localparam int unsigned L = S - 2;
   logic        short_in, zero_in;
   logic [15:0] ux_in, uy_in, uz_in;
   always_comb begin
      short_in = root_ff[L] < min_mag_ff;
      zero_in  = short_in || (root_ff[L] == 16'd0);
      ux_in = zero_in ? 16'd0 : (info_ff[L].sx ? 16'(-{1'b0, qx_ff[L]}) : {1'b0, qx_ff[L]});
      uy_in = zero_in ? 16'd0 : (info_ff[L].sy ? 16'(-{1'b0, qy_ff[L]}) : {1'b0, qy_ff[L]});
      uz_in = zero_in ? 16'd0 : (info_ff[L].sz ? 16'(-{1'b0, qz_ff[L]}) : {1'b0, qz_ff[L]});
   end

   v3n_pkg::rsp_word_type out_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= '{unit_x: ux_in, unit_y: uy_in, unit_z: uz_in,
                     length: root_ff[L], too_short: short_in};
      end
   end

   assign rsp_valid = vld_ff[S-1];
   assign rsp_data  = out_ff;

   // a short result never carries a nonzero unit vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.too_short |-> rsp_data.unit_x == 16'd0 && rsp_data.unit_y == 16'd0
      && rsp_data.unit_z == 16'd0)
      else $error("short vector gave nonzero unit");

   // a stalled pipeline keeps its output word
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_stall) && $past(rsp_valid) && !$past(reset) |-> $stable(rsp_data))
      else $error("output changed under stall");

endmodule

@@ verif/vector3_normalize_top_tb.sv @@
`timescale 1ns / 1ps

class norm_scoreboard;
   v3n_pkg::rsp_word_type pending_q[$];
   logic [15:0] threshold;
   int errors;
   int seen;
   int short_count;

   function new();
      threshold = v3n_pkg::MinMagRst;
      errors = 0;
      seen = 0;
      short_count = 0;
   endfunction

   // floor square root, restoring bit-pair method
   function automatic logic [15:0] root_of(logic [31:0] s);
      logic [31:0] rem;
      logic [31:0] root;
      logic [31:0] b;
      rem = s;
      root = 0;
      b = 32'h4000_0000;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root[15:0];
   endfunction

   function automatic logic [15:0] unit_of(logic signed [15:0] c, logic [15:0] len);
      logic [31:0] mag;
      logic [31:0] q;
      mag = c[15] ? 32'(-$signed({c[15], c})) : 32'(c);
      q = (mag << 14) / len;
      return c[15] ? 16'(-q) : q[15:0];
   endfunction

   function void note_vector(v3n_pkg::req_word_type w);
      v3n_pkg::rsp_word_type e;
      logic [31:0] sum;
      sum = 32'($signed(w.comp_x) * $signed(w.comp_x)) + 32'($signed(w.comp_y) * $signed(w.comp_y))
            + 32'($signed(w.comp_z) * $signed(w.comp_z));
      e.length = root_of(sum);
      e.too_short = e.length < threshold;
      if (e.too_short || e.length == 0) begin
         e.unit_x = 0;
         e.unit_y = 0;
         e.unit_z = 0;
      end else begin
         e.unit_x = unit_of(w.comp_x, e.length);
         e.unit_y = unit_of(w.comp_y, e.length);
         e.unit_z = unit_of(w.comp_z, e.length);
      end
      pending_q.push_back(e);
   endfunction

   function void report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endfunction

   function void check_result(v3n_pkg::rsp_word_type r);
      v3n_pkg::rsp_word_type e;
      if (pending_q.size() == 0) begin
         $display("unexpected result word %h", r);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      seen++;
      if (e.too_short) short_count++;
      if (r.unit_x !== e.unit_x) report("unit_x", $signed(r.unit_x), $signed(e.unit_x));
      if (r.unit_y !== e.unit_y) report("unit_y", $signed(r.unit_y), $signed(e.unit_y));
      if (r.unit_z !== e.unit_z) report("unit_z", $signed(r.unit_z), $signed(e.unit_z));
      if (r.length !== e.length) report("length", r.length, e.length);
      if (r.too_short !== e.too_short) report("too_short", r.too_short, e.too_short);
   endfunction
endclass

module vector3_normalize_top_tb;

   localparam int Latency = v3n_pkg::Stages + 8;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   v3n_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   v3n_pkg::rsp_word_type rsp_data;
   logic                  psel = 0;
   logic                  penable = 0;
   logic                  pwrite = 0;
   logic [2:0]            paddr = 0;
   logic [31:0]           pwdata = 0;
   logic [31:0]           prdata;
   logic                  pready;

   norm_scoreboard board = new();

   // idle rates in percent, changed per phase
   int send_idle = 0;
   int recv_idle = 0;
   // long receiver hold-off, counted in the receiver process
   int hold_cycles = 0;

   always #5 clock = ~clock;

   vector3_normalize_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // result side: check accepted words and decide stall for the next cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   // setup then access cycle, write lands when psel, penable and pready are high
   task automatic write_threshold(logic [15:0] value);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {v3n_pkg::RegMinMag, 1'b0} << 1;
      pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      board.threshold = value;
   endtask

   // offer one word, hold it until accepted, note it in the scoreboard
   task automatic send_vector(v3n_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      board.note_vector(w);
   endtask

   task automatic send_xyz(int x, int y, int z);
      v3n_pkg::req_word_type w;
      w.comp_x = 16'(x);
      w.comp_y = 16'(y);
      w.comp_z = 16'(z);
      send_vector(w);
   endtask

   // stop offering, wait until every expected word came, then let the pipe drain
   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (board.pending_q.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (Latency) @(posedge clock);
   endtask

   // random word: mostly full range, some small vectors near the threshold
   function automatic v3n_pkg::req_word_type random_vector();
      v3n_pkg::req_word_type w;
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) begin
         w = 48'({$urandom, $urandom});
      end else if (pick < 8) begin
         w.comp_x = 16'($signed(16'($urandom_range(0, 600))) - 300);
         w.comp_y = 16'($signed(16'($urandom_range(0, 600))) - 300);
         w.comp_z = 16'($signed(16'($urandom_range(0, 600))) - 300);
      end else begin
         w.comp_x = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
         w.comp_y = 16'($signed(16'($urandom_range(0, 8))) - 4);
         w.comp_z = 16'($urandom);
      end
      return w;
   endfunction

   task automatic random_phase(int count, int sidle, int ridle);
      send_idle = sidle;
      recv_idle = ridle;
      repeat (count) send_vector(random_vector());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes and special cases at reset threshold
      send_xyz(0, 0, 0);                     // zero vector, short at threshold 1
      send_xyz(-32768, -32768, -32768);      // largest magnitude
      send_xyz(32767, 32767, 32767);
      send_xyz(-32768, 0, 0);                // pure axis, unit result
      send_xyz(0, 32767, 0);
      send_xyz(0, 0, -1);                    // tiny negative
      send_xyz(1, 1, 1);
      send_xyz(256, 0, 0);                   // length exactly one
      send_xyz(-3, 4, 0);
      drain();

      // zero threshold: zero vector is not short and its unit result is zero
      write_threshold(16'd0);
      send_xyz(0, 0, 0);
      send_xyz(1, -1, 0);
      drain();

      // top threshold: everything below is short
      write_threshold(16'hffff);
      send_xyz(-32768, -32768, -32768);
      send_xyz(100, 200, -300);
      drain();

      // threshold right at a known length, boundary either way
      write_threshold(16'd256);
      send_xyz(256, 0, 0);
      send_xyz(255, 0, 0);
      send_xyz(0, 0, -256);
      drain();

      write_threshold(16'd100);
      random_phase(330, 11, 49);
      drain();

      write_threshold(16'd0);
      random_phase(330, 49, 11);

      // long receiver hold-off while the sender keeps offering
      hold_cycles = 120;
      random_phase(80, 0, 0);
      drain();

      // threshold back to 1, then a phase with no idling on either side
      write_threshold(16'd1);
      random_phase(300, 0, 0);
      drain();

      $display("covered %0d result words, %0d short, thresholds 0, 1, 100, 256 and 65535",
               board.seen, board.short_count);
      $display("idling mixes 11/49, 49/11 and none, plus one long result hold-off");
      if (board.errors == 0 && board.pending_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule
